FILE: hw/rtl/bsrpc_pkg.sv
// bsrpc_pkg: types, sizes, mode codes and the popcount function of the
// bitset row and popcount counter. No dependencies.
package bsrpc_pkg;

    localparam int BLOCK_WORDS = 32;
    localparam int ROW_COUNT   = 512;
    localparam int BLOCK_COUNT = 1;

    localparam int STORE_WORDS = BLOCK_COUNT * ROW_COUNT * BLOCK_WORDS;
    localparam int SA_W        = $clog2(STORE_WORDS);
    localparam int AW_W        = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int CNT_W       = $clog2(64 * BLOCK_WORDS + 1);
    localparam int PC_W        = 7;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_INDEX = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [13:0] load_address;
        logic [63:0] load_data;
        logic [0:0]  block_number;
        logic [8:0]  bit_position;
        logic        group_end;
    } t_in_word;

    typedef struct packed {
        logic [11:0] group_count;
        logic [63:0] running_total;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } t_state;

    // bit-parallel popcount, six narrow steps
    function automatic logic [PC_W-1:0] popcount64(input logic [63:0] v);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        logic [63:0] e;
        logic [63:0] f;
        a = (v & 64'h5555555555555555) + ((v >> 1) & 64'h5555555555555555);
        b = (a & 64'h3333333333333333) + ((a >> 2) & 64'h3333333333333333);
        c = (b & 64'h0F0F0F0F0F0F0F0F) + ((b >> 4) & 64'h0F0F0F0F0F0F0F0F);
        d = (c & 64'h00FF00FF00FF00FF) + ((c >> 8) & 64'h00FF00FF00FF00FF);
        e = (d & 64'h0000FFFF0000FFFF) + ((d >> 16) & 64'h0000FFFF0000FFFF);
        f = (e & 64'h00000000FFFFFFFF) + ((e >> 32) & 64'h00000000FFFFFFFF);
        return f[PC_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/bitset_row_and_popcount_counter_core.sv
// bitset_row_and_popcount_counter_core: top level, store and accumulator rams
// with the index sequencer. Depends on bsrpc_pkg and bsrpc_ram.
// Load and start words complete on acceptance. An index word is accepted, then
// one store and accumulator read is issued per row word, then the sequencer
// waits while the last word's and/write-back drains. A group end adds the
// popcount stage and the total update, and the result waits in an output
// register, holding off the next group end until taken.
// Synchronous active-low reset clears total, accumulator valid bits and control.
module bitset_row_and_popcount_counter_core
    import bsrpc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    t_state r_state, n_state;

    logic [SA_W-1:0]        r_saddr, n_saddr;
    logic [AW_W-1:0]        r_widx, n_widx;
    logic                   r_skip, n_skip;
    logic                   r_end, n_end;
    logic [BLOCK_WORDS-1:0] r_acc_vld, n_acc_vld;
    logic                   r_p1_v;
    logic [AW_W-1:0]        r_p1_idx;
    logic                   r_p1_vld;
    logic                   r_p2_v;
    logic [PC_W-1:0]        r_pc;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [63:0]            r_total, n_total;
    logic                   r_out_valid, n_out_valid;
    t_out_word              r_out_data, n_out_data;

    logic        accept;
    logic        issue;
    logic        finish_go;
    logic        store_we;
    logic [SA_W+13:0] load_ext;
    logic [SA_W-1:0]  store_raddr;
    logic [63:0] store_rdata;
    logic [63:0] acc_rdata;
    logic [63:0] and_word;
    logic        acc_we;
    logic [31:0] base_full;
    logic        in_range;
    logic [CNT_W+11:0] cnt_ext;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign issue      = (r_state == S_RUN);
    assign finish_go  = (r_state == S_FINISH) && (!r_out_valid || i_out_ready);

    // load writes go straight to the store while idle
    assign load_ext    = {{SA_W{1'b0}}, i_in_data.load_address};
    assign store_we    = accept && (i_in_data.mode == MODE_LOAD)
                         && (32'(i_in_data.load_address) < STORE_WORDS);
    assign store_raddr = r_saddr;

    bsrpc_ram #(
        .WIDTH (64),
        .DEPTH (STORE_WORDS),
        .AW    (SA_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (load_ext[SA_W-1:0]),
        .i_wdata (i_in_data.load_data),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    // accumulator: read word w while word w-1 is written back (no write-back on a group end)
    assign and_word = (r_p1_vld ? acc_rdata : '1) & (r_skip ? '1 : store_rdata);
    assign acc_we   = r_p1_v && !r_end;

    bsrpc_ram #(
        .WIDTH (64),
        .DEPTH (BLOCK_WORDS),
        .AW    (AW_W)
    ) u_acc (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (r_p1_idx),
        .i_wdata (and_word),
        .i_raddr (r_widx),
        .o_rdata (acc_rdata)
    );

    assign base_full = (32'(i_in_data.block_number) * 32'(ROW_COUNT)
                        + 32'(i_in_data.bit_position)) * 32'(BLOCK_WORDS);
    assign in_range  = (32'(i_in_data.block_number) < BLOCK_COUNT)
                       && (32'(i_in_data.bit_position) < ROW_COUNT);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_in_data.mode == MODE_INDEX)) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_widx == AW_W'(BLOCK_WORDS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_p1_v && !r_p2_v) begin
                    n_state = r_end ? S_FINISH : S_IDLE;
                end
            end
            S_FINISH: begin
                if (finish_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_saddr     = r_saddr;
        n_widx      = r_widx;
        n_skip      = r_skip;
        n_end       = r_end;
        n_acc_vld   = r_acc_vld;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        cnt_ext     = {12'd0, r_cnt};

        if (accept) begin
            unique case (i_in_data.mode)
                MODE_INDEX: begin
                    n_saddr = base_full[SA_W-1:0];
                    n_widx  = '0;
                    n_skip  = !in_range;
                    n_end   = i_in_data.group_end;
                end
                MODE_START: begin
                    n_total   = '0;
                    n_acc_vld = '0;
                end
                default: begin
                end
            endcase
        end

        if (issue) begin
            n_saddr = SA_W'(r_saddr + 1'b1);
            n_widx  = AW_W'(r_widx + 1'b1);
        end

        if (acc_we) begin
            n_acc_vld[r_p1_idx] = 1'b1;
        end

        if (r_p2_v) begin
            n_cnt = CNT_W'(r_cnt + CNT_W'(r_pc));
        end

        if (finish_go) begin
            n_total                  = r_total + 64'(r_cnt);
            n_out_valid              = 1'b1;
            n_out_data.group_count   = cnt_ext[11:0];
            n_out_data.running_total = r_total + 64'(r_cnt);
            n_cnt                    = '0;
            n_acc_vld                = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc_vld   <= '0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_cnt       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc_vld   <= n_acc_vld;
            r_p1_v      <= issue;
            r_p2_v      <= r_p1_v && r_end;
            r_cnt       <= n_cnt;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_saddr    <= n_saddr;
        r_widx     <= n_widx;
        r_skip     <= n_skip;
        r_end      <= n_end;
        r_p1_idx   <= r_widx;
        r_p1_vld   <= r_acc_vld[r_widx];
        r_pc       <= popcount64(and_word);
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: hw/rtl/bsrpc_ram.sv
// bsrpc_ram: generic simple dual-port ram, one write and one registered read
// port. No dependencies.
module bsrpc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
